/* rtl/core/hed_pkg.sv */
// hed_pkg: shared types, constants and the named-reference rom for the html entity decoder
// depends on nothing; used by hed_ctrl, hed_dp and the top level
package hed_pkg;

    localparam int MaxPending = 32;
    localparam int NameCount  = 253;
    localparam int RomLen     = 253;
    localparam int HeldAw     = $clog2(MaxPending);
    localparam int CntW       = $clog2(MaxPending + 1);
    localparam int RomAw      = $clog2(RomLen);

    localparam logic [7:0]  ChAmp  = 8'h26;
    localparam logic [7:0]  ChSemi = 8'h3B;
    localparam logic [7:0]  ChHash = 8'h23;
    localparam logic [20:0] CpLimit = 21'h10FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UTF8,
        ST_FLUSH,
        ST_LIT,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic store_byte;
        logic start_ref;
        logic clear_held;
        logic search_clr;
        logic search_step;
        logic utf8_load;
        logic utf8_step;
        logic flush_clr;
        logic flush_step;
        logic emit_lit;
        logic emit_held;
        logic emit_utf8;
        logic emit_last;
        logic emit_done;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       is_amp;
        logic       is_semi;
        logic       eoi;
        logic       held_zero;
        logic       held_full;
        logic       num_kind;
        logic       num_ok;
        logic       name_len_ok;
        logic       search_hit;
        logic       search_end;
        logic       utf8_last;
        logic       flush_last;
    } dp_sts_t;

    typedef struct packed {
        logic [3:0]  len;
        logic [63:0] nm;
        logic [20:0] cp;
    } rom_ent_t;

    function automatic rom_ent_t rom_mk(input string s, input logic [20:0] cp);
        rom_ent_t e;
        e.len = 4'(s.len());
        e.nm  = '0;
        e.cp  = cp;
        for (int i = 0; i < 8; i++) begin
            if (i < s.len()) e.nm[i*8 +: 8] = s[i];
        end
        return e;
    endfunction

    function automatic rom_ent_t rom_at(input logic [RomAw-1:0] a);
        case (a)
        0: return rom_mk("AElig",'hC6); 1: return rom_mk("Aacute",'hC1);
        2: return rom_mk("Acirc",'hC2); 3: return rom_mk("Agrave",'hC0);
        4: return rom_mk("Alpha",'h391); 5: return rom_mk("Aring",'hC5);
        6: return rom_mk("Atilde",'hC3); 7: return rom_mk("Auml",'hC4);
        8: return rom_mk("Beta",'h392); 9: return rom_mk("Ccedil",'hC7);
        10: return rom_mk("Chi",'h3A7); 11: return rom_mk("Dagger",'h2021);
        12: return rom_mk("Delta",'h394); 13: return rom_mk("ETH",'hD0);
        14: return rom_mk("Eacute",'hC9); 15: return rom_mk("Ecirc",'hCA);
        16: return rom_mk("Egrave",'hC8); 17: return rom_mk("Epsilon",'h395);
        18: return rom_mk("Eta",'h397); 19: return rom_mk("Euml",'hCB);
        20: return rom_mk("Gamma",'h393); 21: return rom_mk("Iacute",'hCD);
        22: return rom_mk("Icirc",'hCE); 23: return rom_mk("Igrave",'hCC);
        24: return rom_mk("Iota",'h399); 25: return rom_mk("Iuml",'hCF);
        26: return rom_mk("Kappa",'h39A); 27: return rom_mk("Lambda",'h39B);
        28: return rom_mk("Mu",'h39C); 29: return rom_mk("Ntilde",'hD1);
        30: return rom_mk("Nu",'h39D); 31: return rom_mk("OElig",'h152);
        32: return rom_mk("Oacute",'hD3); 33: return rom_mk("Ocirc",'hD4);
        34: return rom_mk("Ograve",'hD2); 35: return rom_mk("Omega",'h3A9);
        36: return rom_mk("Omicron",'h39F); 37: return rom_mk("Oslash",'hD8);
        38: return rom_mk("Otilde",'hD5); 39: return rom_mk("Ouml",'hD6);
        40: return rom_mk("Phi",'h3A6); 41: return rom_mk("Pi",'h3A0);
        42: return rom_mk("Prime",'h2033); 43: return rom_mk("Psi",'h3A8);
        44: return rom_mk("Rho",'h3A1); 45: return rom_mk("Scaron",'h160);
        46: return rom_mk("Sigma",'h3A3); 47: return rom_mk("THORN",'hDE);
        48: return rom_mk("Tau",'h3A4); 49: return rom_mk("Theta",'h398);
        50: return rom_mk("Uacute",'hDA); 51: return rom_mk("Ucirc",'hDB);
        52: return rom_mk("Ugrave",'hD9); 53: return rom_mk("Upsilon",'h3A5);
        54: return rom_mk("Uuml",'hDC); 55: return rom_mk("Xi",'h39E);
        56: return rom_mk("Yacute",'hDD); 57: return rom_mk("Yuml",'h178);
        58: return rom_mk("Zeta",'h396); 59: return rom_mk("aacute",'hE1);
        60: return rom_mk("acirc",'hE2); 61: return rom_mk("acute",'hB4);
        62: return rom_mk("aelig",'hE6); 63: return rom_mk("agrave",'hE0);
        64: return rom_mk("alefsym",'h2135); 65: return rom_mk("alpha",'h3B1);
        66: return rom_mk("amp",'h26); 67: return rom_mk("and",'h2227);
        68: return rom_mk("ang",'h2220); 69: return rom_mk("apos",'h27);
        70: return rom_mk("aring",'hE5); 71: return rom_mk("asymp",'h2248);
        72: return rom_mk("atilde",'hE3); 73: return rom_mk("auml",'hE4);
        74: return rom_mk("bdquo",'h201E); 75: return rom_mk("beta",'h3B2);
        76: return rom_mk("brvbar",'hA6); 77: return rom_mk("bull",'h2022);
        78: return rom_mk("cap",'h2229); 79: return rom_mk("ccedil",'hE7);
        80: return rom_mk("cedil",'hB8); 81: return rom_mk("cent",'hA2);
        82: return rom_mk("chi",'h3C7); 83: return rom_mk("circ",'h2C6);
        84: return rom_mk("clubs",'h2663); 85: return rom_mk("cong",'h2245);
        86: return rom_mk("copy",'hA9); 87: return rom_mk("crarr",'h21B5);
        88: return rom_mk("cup",'h222A); 89: return rom_mk("curren",'hA4);
        90: return rom_mk("dArr",'h21D3); 91: return rom_mk("dagger",'h2020);
        92: return rom_mk("darr",'h2193); 93: return rom_mk("deg",'hB0);
        94: return rom_mk("delta",'h3B4); 95: return rom_mk("diams",'h2666);
        96: return rom_mk("divide",'hF7); 97: return rom_mk("eacute",'hE9);
        98: return rom_mk("ecirc",'hEA); 99: return rom_mk("egrave",'hE8);
        100: return rom_mk("empty",'h2205); 101: return rom_mk("emsp",'h2003);
        102: return rom_mk("ensp",'h2002); 103: return rom_mk("epsilon",'h3B5);
        104: return rom_mk("equiv",'h2261); 105: return rom_mk("eta",'h3B7);
        106: return rom_mk("eth",'hF0); 107: return rom_mk("euml",'hEB);
        108: return rom_mk("euro",'h20AC); 109: return rom_mk("exist",'h2203);
        110: return rom_mk("fnof",'h192); 111: return rom_mk("forall",'h2200);
        112: return rom_mk("frac12",'hBD); 113: return rom_mk("frac14",'hBC);
        114: return rom_mk("frac34",'hBE); 115: return rom_mk("frasl",'h2044);
        116: return rom_mk("gamma",'h3B3); 117: return rom_mk("ge",'h2265);
        118: return rom_mk("gt",'h3E); 119: return rom_mk("hArr",'h21D4);
        120: return rom_mk("harr",'h2194); 121: return rom_mk("hearts",'h2665);
        122: return rom_mk("hellip",'h2026); 123: return rom_mk("iacute",'hED);
        124: return rom_mk("icirc",'hEE); 125: return rom_mk("iexcl",'hA1);
        126: return rom_mk("igrave",'hEC); 127: return rom_mk("image",'h2111);
        128: return rom_mk("infin",'h221E); 129: return rom_mk("int",'h222B);
        130: return rom_mk("iota",'h3B9); 131: return rom_mk("iquest",'hBF);
        132: return rom_mk("isin",'h2208); 133: return rom_mk("iuml",'hEF);
        134: return rom_mk("kappa",'h3BA); 135: return rom_mk("lArr",'h21D0);
        136: return rom_mk("lambda",'h3BB); 137: return rom_mk("lang",'h2329);
        138: return rom_mk("laquo",'hAB); 139: return rom_mk("larr",'h2190);
        140: return rom_mk("lceil",'h2308); 141: return rom_mk("ldquo",'h201C);
        142: return rom_mk("le",'h2264); 143: return rom_mk("lfloor",'h230A);
        144: return rom_mk("lowast",'h2217); 145: return rom_mk("loz",'h25CA);
        146: return rom_mk("lrm",'h200E); 147: return rom_mk("lsaquo",'h2039);
        148: return rom_mk("lsquo",'h2018); 149: return rom_mk("lt",'h3C);
        150: return rom_mk("macr",'hAF); 151: return rom_mk("mdash",'h2014);
        152: return rom_mk("micro",'hB5); 153: return rom_mk("middot",'hB7);
        154: return rom_mk("minus",'h2212); 155: return rom_mk("mu",'h3BC);
        156: return rom_mk("nabla",'h2207); 157: return rom_mk("nbsp",'hA0);
        158: return rom_mk("ndash",'h2013); 159: return rom_mk("ne",'h2260);
        160: return rom_mk("ni",'h220B); 161: return rom_mk("not",'hAC);
        162: return rom_mk("notin",'h2209); 163: return rom_mk("nsub",'h2284);
        164: return rom_mk("ntilde",'hF1); 165: return rom_mk("nu",'h3BD);
        166: return rom_mk("oacute",'hF3); 167: return rom_mk("ocirc",'hF4);
        168: return rom_mk("oelig",'h153); 169: return rom_mk("ograve",'hF2);
        170: return rom_mk("oline",'h203E); 171: return rom_mk("omega",'h3C9);
        172: return rom_mk("omicron",'h3BF); 173: return rom_mk("oplus",'h2295);
        174: return rom_mk("or",'h2228); 175: return rom_mk("ordf",'hAA);
        176: return rom_mk("ordm",'hBA); 177: return rom_mk("oslash",'hF8);
        178: return rom_mk("otilde",'hF5); 179: return rom_mk("otimes",'h2297);
        180: return rom_mk("ouml",'hF6); 181: return rom_mk("para",'hB6);
        182: return rom_mk("part",'h2202); 183: return rom_mk("permil",'h2030);
        184: return rom_mk("perp",'h22A5); 185: return rom_mk("phi",'h3C6);
        186: return rom_mk("pi",'h3C0); 187: return rom_mk("piv",'h3D6);
        188: return rom_mk("plusmn",'hB1); 189: return rom_mk("pound",'hA3);
        190: return rom_mk("prime",'h2032); 191: return rom_mk("prod",'h220F);
        192: return rom_mk("prop",'h221D); 193: return rom_mk("psi",'h3C8);
        194: return rom_mk("quot",'h22); 195: return rom_mk("rArr",'h21D2);
        196: return rom_mk("radic",'h221A); 197: return rom_mk("rang",'h232A);
        198: return rom_mk("raquo",'hBB); 199: return rom_mk("rarr",'h2192);
        200: return rom_mk("rceil",'h2309); 201: return rom_mk("rdquo",'h201D);
        202: return rom_mk("real",'h211C); 203: return rom_mk("reg",'hAE);
        204: return rom_mk("rfloor",'h230B); 205: return rom_mk("rho",'h3C1);
        206: return rom_mk("rlm",'h200F); 207: return rom_mk("rsaquo",'h203A);
        208: return rom_mk("rsquo",'h2019); 209: return rom_mk("sbquo",'h201A);
        210: return rom_mk("scaron",'h161); 211: return rom_mk("sdot",'h22C5);
        212: return rom_mk("sect",'hA7); 213: return rom_mk("shy",'hAD);
        214: return rom_mk("sigma",'h3C3); 215: return rom_mk("sigmaf",'h3C2);
        216: return rom_mk("sim",'h223C); 217: return rom_mk("spades",'h2660);
        218: return rom_mk("sub",'h2282); 219: return rom_mk("sube",'h2286);
        220: return rom_mk("sum",'h2211); 221: return rom_mk("sup",'h2283);
        222: return rom_mk("sup1",'hB9); 223: return rom_mk("sup2",'hB2);
        224: return rom_mk("sup3",'hB3); 225: return rom_mk("supe",'h2287);
        226: return rom_mk("szlig",'hDF); 227: return rom_mk("tau",'h3C4);
        228: return rom_mk("there4",'h2234); 229: return rom_mk("theta",'h3B8);
        230: return rom_mk("thetasym",'h3D1); 231: return rom_mk("thinsp",'h2009);
        232: return rom_mk("thorn",'hFE); 233: return rom_mk("tilde",'h2DC);
        234: return rom_mk("times",'hD7); 235: return rom_mk("trade",'h2122);
        236: return rom_mk("uArr",'h21D1); 237: return rom_mk("uacute",'hFA);
        238: return rom_mk("uarr",'h2191); 239: return rom_mk("ucirc",'hFB);
        240: return rom_mk("ugrave",'hF9); 241: return rom_mk("uml",'hA8);
        242: return rom_mk("upsih",'h3D2); 243: return rom_mk("upsilon",'h3C5);
        244: return rom_mk("uuml",'hFC); 245: return rom_mk("weierp",'h2118);
        246: return rom_mk("xi",'h3BE); 247: return rom_mk("yacute",'hFD);
        248: return rom_mk("yen",'hA5); 249: return rom_mk("yuml",'hFF);
        250: return rom_mk("zeta",'h3B6); 251: return rom_mk("zwj",'h200D);
        252: return rom_mk("zwnj",'h200C);
        default: return rom_mk("", '0);
        endcase
    endfunction

endpackage

/* rtl/core/html_entity_to_utf8_decoder_top.sv */
// html_entity_to_utf8_decoder_top: top level of the html character reference decoder
// depends on hed_pkg, hed_ctrl and hed_dp
// an item is accepted in ST_IDLE and dispatched in ST_LIT in the next cycle; a named
// reference searches the rom one entry at a time, and a flush reads and then emits
// each held byte; one item at a time, paced by the controller
// reset: asynchronous active low, clears the held count, numeric state and the fsm
module html_entity_to_utf8_decoder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hed_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hed_pkg::out_item_t out_data
);

    hed_pkg::dp_cmd_t cmd;
    hed_pkg::dp_sts_t sts;

    // controller: sequences accept, store, search, encode and flush
    hed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: held-byte memory, numeric accumulator, rom, utf-8 byte builder
    hed_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_data)
    );

endmodule

/* rtl/core/hed_dp.sv */
// hed_dp: datapath with held-byte memory, numeric accumulator, rom search and utf-8 encoder
// depends on hed_pkg
module hed_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  hed_pkg::in_item_t  in_item,
    input  hed_pkg::dp_cmd_t   cmd,
    output hed_pkg::dp_sts_t   sts,
    output hed_pkg::out_item_t out_item
);

    logic [7:0]                   held_mem [hed_pkg::MaxPending];
    logic [63:0]                  name_reg;
    logic [7:0]                   byte_reg;
    logic                         eoi_reg;
    logic [hed_pkg::CntW-1:0]     cnt_reg;
    logic [20:0]                  num_reg;
    logic                         ovf_reg;
    logic                         hash_reg;
    logic                         hex_reg;
    logic [hed_pkg::RomAw-1:0]    rom_idx_reg;
    logic                         hit_reg;
    logic [20:0]                  cp_reg;
    logic [2:0]                   u_idx_reg;
    logic [2:0]                   u_len_reg;
    logic [hed_pkg::HeldAw-1:0]   fl_idx_reg;
    logic [7:0]                   fl_byte_reg;
    hed_pkg::out_item_t           out_reg;

    logic       is_x;
    logic [4:0] dig;
    logic       dig_ok;
    logic [25:0] acc;
    hed_pkg::rom_ent_t ent;
    logic [7:0] u_byte;
    logic [hed_pkg::HeldAw-1:0] wr_idx;

    assign is_x   = (byte_reg == "x") || (byte_reg == "X");
    assign wr_idx = cnt_reg[hed_pkg::HeldAw-1:0];

    always_comb
    begin
        dig = 5'd16;
        if (byte_reg >= "0" && byte_reg <= "9") dig = 5'(byte_reg - "0");
        else if (hex_reg && byte_reg >= "a" && byte_reg <= "f") dig = 5'(byte_reg - "a" + 10);
        else if (hex_reg && byte_reg >= "A" && byte_reg <= "F") dig = 5'(byte_reg - "A" + 10);
        dig_ok = (dig != 5'd16);
        acc = hex_reg ? {num_reg, 4'd0} + 26'(dig[3:0])
                      : {2'd0, num_reg, 3'd0} + {4'd0, num_reg, 1'b0} + 26'(dig[3:0]);
    end

    assign ent = hed_pkg::rom_at(rom_idx_reg);

    always_comb
    begin
        case (u_len_reg)
        3'd1: u_byte = {1'b0, cp_reg[6:0]};
        3'd2: u_byte = (u_idx_reg == 3'd0) ? {3'b110, cp_reg[10:6]} : {2'b10, cp_reg[5:0]};
        3'd3:
            case (u_idx_reg)
            3'd0:    u_byte = {4'b1110, cp_reg[15:12]};
            3'd1:    u_byte = {2'b10, cp_reg[11:6]};
            default: u_byte = {2'b10, cp_reg[5:0]};
            endcase
        default:
            case (u_idx_reg)
            3'd0:    u_byte = {5'b11110, cp_reg[20:18]};
            3'd1:    u_byte = {2'b10, cp_reg[17:12]};
            3'd2:    u_byte = {2'b10, cp_reg[11:6]};
            default: u_byte = {2'b10, cp_reg[5:0]};
            endcase
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte) held_mem[wr_idx] <= byte_reg;
        if (cmd.start_ref)  held_mem[0] <= hed_pkg::ChAmp;
        fl_byte_reg <= held_mem[fl_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            num_reg     <= '0;
            ovf_reg     <= 1'b0;
            hash_reg    <= 1'b0;
            hex_reg     <= 1'b0;
            rom_idx_reg <= '0;
            hit_reg     <= 1'b0;
            u_idx_reg   <= '0;
            fl_idx_reg  <= '0;
            out_reg     <= '0;
            eoi_reg     <= 1'b0;
            byte_reg    <= '0;
            name_reg    <= '0;
            cp_reg      <= '0;
            u_len_reg   <= 3'd1;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                byte_reg <= in_item.in_byte;
                eoi_reg  <= in_item.end_of_input;
            end
            if (cmd.start_ref)
            begin
                cnt_reg  <= hed_pkg::CntW'(1);
                num_reg  <= '0;
                ovf_reg  <= 1'b0;
                hash_reg <= 1'b0;
                hex_reg  <= 1'b0;
                name_reg <= '0;
            end
            else if (cmd.store_byte)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg <= 8 && cnt_reg >= 1)
                    name_reg[(cnt_reg - 1) * 8 +: 8] <= byte_reg;
                if (cnt_reg == 1) hash_reg <= (byte_reg == hed_pkg::ChHash);
                if (hash_reg && cnt_reg >= 2)
                begin
                    if (cnt_reg == 2 && is_x) hex_reg <= 1'b1;
                    else if (!ovf_reg)
                    begin
                        if (!dig_ok || acc > 26'(hed_pkg::CpLimit)) ovf_reg <= 1'b1;
                        else num_reg <= acc[20:0];
                    end
                end
            end
            else if (cmd.clear_held) cnt_reg <= '0;

            if (cmd.search_clr)
            begin
                rom_idx_reg <= '0;
                hit_reg     <= 1'b0;
            end
            else if (cmd.search_step)
            begin
                if (ent.len == 4'(cnt_reg - 1) && ent.nm == name_reg
                    && 32'(rom_idx_reg) < hed_pkg::NameCount)
                begin
                    hit_reg <= 1'b1;
                    cp_reg  <= ent.cp;
                end
                else rom_idx_reg <= rom_idx_reg + 1'b1;
            end

            if (cmd.utf8_load)
            begin
                u_idx_reg <= '0;
                if (hash_reg) cp_reg <= num_reg;
                u_len_reg <= (hash_reg ? num_reg : cp_reg) <= 21'h7F ? 3'd1 :
                             (hash_reg ? num_reg : cp_reg) <= 21'h7FF ? 3'd2 :
                             (hash_reg ? num_reg : cp_reg) <= 21'hFFFF ? 3'd3 : 3'd4;
            end
            else if (cmd.utf8_step) u_idx_reg <= u_idx_reg + 1'b1;

            if (cmd.flush_clr) fl_idx_reg <= '0;
            else if (cmd.flush_step) fl_idx_reg <= fl_idx_reg + 1'b1;

            if (cmd.emit_lit || cmd.emit_held || cmd.emit_utf8)
            begin
                out_reg.out_byte    <= cmd.emit_lit ? byte_reg :
                                       cmd.emit_held ? fl_byte_reg : u_byte;
                out_reg.last_of_run <= cmd.emit_last;
                out_reg.stream_done <= cmd.emit_done;
            end
        end
    end

    always_comb
    begin
        sts.is_amp      = (byte_reg == hed_pkg::ChAmp);
        sts.is_semi     = (byte_reg == hed_pkg::ChSemi);
        sts.eoi         = eoi_reg;
        sts.held_zero   = (cnt_reg == '0);
        sts.held_full   = (cnt_reg >= hed_pkg::CntW'(hed_pkg::MaxPending));
        sts.num_kind    = hash_reg;
        sts.num_ok      = (cnt_reg >= 3) && !ovf_reg && !(hex_reg && cnt_reg < 4);
        sts.name_len_ok = (cnt_reg >= 3) && (cnt_reg <= 9);
        sts.search_hit  = hit_reg;
        // index has moved past the last entry that takes part
        sts.search_end  = (32'(rom_idx_reg) >= hed_pkg::RomLen)
                          || (32'(rom_idx_reg) >= hed_pkg::NameCount);
        sts.utf8_last   = (u_idx_reg == u_len_reg - 3'd1);
        sts.flush_last  = (hed_pkg::CntW'(fl_idx_reg) + 1'b1 >= cnt_reg);
    end

    assign out_item = out_reg;

endmodule

/* rtl/core/hed_ctrl.sv */
// hed_ctrl: sequencer for the html entity decoder
// depends on hed_pkg; drives hed_dp through dp_cmd_t
module hed_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  hed_pkg::dp_sts_t sts,
    output hed_pkg::dp_cmd_t cmd
);

    hed_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic            phase_reg, phase_next;   // flush: 0 = address, 1 = data ready
    logic            tail_reg, tail_next;     // flush followed by literal byte
    logic            restart_reg, restart_next;
    logic            step_done_reg, step_done_next;
    logic            search_wait_reg, search_wait_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hed_pkg::ST_IDLE;
            ret_reg         <= hed_pkg::ST_IDLE;
            phase_reg       <= 1'b0;
            tail_reg        <= 1'b0;
            restart_reg     <= 1'b0;
            step_done_reg   <= 1'b0;
            search_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            phase_reg       <= phase_next;
            tail_reg        <= tail_next;
            restart_reg     <= restart_next;
            step_done_reg   <= step_done_next;
            search_wait_reg <= search_wait_next;
        end
    end

    logic outfree;
    assign outfree = !out_valid || out_ready;

    // next state and commands; the latched item is dispatched in ST_LIT in the cycle after accept
    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        phase_next       = phase_reg;
        tail_next        = tail_reg;
        restart_next     = restart_reg;
        step_done_next   = step_done_reg;
        search_wait_next = search_wait_reg;
        cmd              = '0;
        case (state_reg)
        hed_pkg::ST_IDLE:
            if (in_valid)
            begin
                cmd.latch_in = 1'b1;
                state_next   = hed_pkg::ST_LIT;
                step_done_next = 1'b0;
            end
        hed_pkg::ST_LIT:
            // dispatch the latched byte
            if (step_done_reg)
            begin
                if (sts.eoi && !sts.held_zero)
                begin
                    cmd.flush_clr = 1'b1;
                    phase_next = 1'b0; tail_next = 1'b0; restart_next = 1'b0;
                    state_next = hed_pkg::ST_FLUSH;
                end
                else state_next = hed_pkg::ST_IDLE;
            end
            else if (sts.held_zero)
            begin
                if (sts.is_amp)
                begin
                    cmd.start_ref = 1'b1;
                    step_done_next = 1'b1;
                end
                else if (outfree)
                begin
                    cmd.emit_lit  = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_done = sts.eoi;
                    state_next    = hed_pkg::ST_OUT;
                end
            end
            else if (sts.is_amp)
            begin
                cmd.flush_clr = 1'b1;
                phase_next = 1'b0; tail_next = 1'b0; restart_next = 1'b1;
                state_next = hed_pkg::ST_FLUSH;
            end
            else if (sts.is_semi)
            begin
                if (sts.num_kind ? sts.num_ok : sts.name_len_ok)
                begin
                    cmd.search_clr = 1'b1;
                    search_wait_next = 1'b0;
                    state_next = hed_pkg::ST_SEARCH;
                end
                else
                begin
                    cmd.flush_clr = 1'b1;
                    phase_next = 1'b0; tail_next = 1'b1; restart_next = 1'b0;
                    state_next = hed_pkg::ST_FLUSH;
                end
            end
            else if (sts.held_full)
            begin
                cmd.flush_clr = 1'b1;
                phase_next = 1'b0; tail_next = 1'b1; restart_next = 1'b0;
                state_next = hed_pkg::ST_FLUSH;
            end
            else
            begin
                cmd.store_byte = 1'b1;
                step_done_next = 1'b1;
            end
        hed_pkg::ST_SEARCH:
            if (sts.num_kind)
            begin
                cmd.utf8_load = 1'b1;
                state_next = hed_pkg::ST_UTF8;
            end
            else if (search_wait_reg)
            begin
                // the cycle after a step: hit is visible
                search_wait_next = 1'b0;
                if (sts.search_hit)
                begin
                    cmd.utf8_load = 1'b1;
                    state_next = hed_pkg::ST_UTF8;
                end
                else if (sts.search_end)
                begin
                    cmd.flush_clr = 1'b1;
                    phase_next = 1'b0; tail_next = 1'b1; restart_next = 1'b0;
                    state_next = hed_pkg::ST_FLUSH;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                    search_wait_next = 1'b1;
                end
            end
            else
            begin
                cmd.search_step = 1'b1;
                search_wait_next = 1'b1;
            end
        hed_pkg::ST_UTF8:
            if (outfree)
            begin
                cmd.emit_utf8 = 1'b1;
                cmd.utf8_step = 1'b1;
                if (sts.utf8_last)
                begin
                    cmd.clear_held = 1'b1;
                    cmd.emit_last  = 1'b1;
                    cmd.emit_done  = sts.eoi;
                    ret_next   = hed_pkg::ST_IDLE;
                    state_next = hed_pkg::ST_OUT;
                end
            end
        hed_pkg::ST_FLUSH:
            if (!phase_reg)
            begin
                // memory read in flight
                phase_next = 1'b1;
            end
            else if (outfree)
            begin
                cmd.emit_held = 1'b1;
                if (sts.flush_last)
                begin
                    cmd.clear_held = !restart_reg;
                    cmd.start_ref  = restart_reg;
                    if (tail_reg)
                    begin
                        cmd.emit_last = 1'b0;
                        state_next = hed_pkg::ST_LIT;
                        step_done_next = 1'b0;
                    end
                    else if (restart_reg)
                    begin
                        // restart with eoi still to flush the new '&'
                        cmd.emit_last = !sts.eoi;
                        state_next = hed_pkg::ST_LIT;
                        step_done_next = 1'b1;
                        restart_next = 1'b0;
                    end
                    else
                    begin
                        cmd.emit_last = 1'b1;
                        cmd.emit_done = sts.eoi;
                        ret_next   = hed_pkg::ST_IDLE;
                        state_next = hed_pkg::ST_OUT;
                    end
                end
                else
                begin
                    cmd.flush_step = 1'b1;
                    phase_next = 1'b0;
                end
            end
        hed_pkg::ST_OUT:
            state_next = hed_pkg::ST_IDLE;
        default:
            state_next = hed_pkg::ST_IDLE;
        endcase
    end

    // output valid tracking
    logic ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ov_reg <= 1'b0;
        else if (cmd.emit_lit || cmd.emit_held || cmd.emit_utf8) ov_reg <= 1'b1;
        else if (out_ready) ov_reg <= 1'b0;
    end

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == hed_pkg::ST_IDLE);

endmodule
